// ===== rtl/core/register_alu_execute_unit_defines.svh =====
// assertion macros for the register alu execute unit
`ifndef REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH
`define REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RAEU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RAEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/raeu_pkg.sv =====
// shared constants and command codes for the register alu execute unit
`default_nettype none

package raeu_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_AW   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DATA_W   = 16;
  localparam int FLAG_W   = 5;
  localparam int CMD_W    = 5;
  localparam int IDX_W    = 3;

  localparam int FLAG_C   = 0;
  localparam int FLAG_V   = 1;
  localparam int FLAG_N   = 2;
  localparam int FLAG_Z   = 3;
  localparam int FLAG_SLP = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 5'd0,
    CMD_ADDC  = 5'd1,
    CMD_SUB   = 5'd2,
    CMD_SUBC  = 5'd3,
    CMD_CMP   = 5'd4,
    CMD_XOR   = 5'd5,
    CMD_AND   = 5'd6,
    CMD_OR    = 5'd7,
    CMD_BIT   = 5'd8,
    CMD_BIC   = 5'd9,
    CMD_BIS   = 5'd10,
    CMD_MOV   = 5'd11,
    CMD_SWAP  = 5'd12,
    CMD_SRA   = 5'd13,
    CMD_RRC   = 5'd14,
    CMD_SWPB  = 5'd15,
    CMD_SXT   = 5'd16,
    CMD_MOVL  = 5'd17,
    CMD_MOVLZ = 5'd18,
    CMD_MOVLS = 5'd19,
    CMD_MOVH  = 5'd20,
    CMD_SETCC = 5'd21,
    CMD_CLRCC = 5'd22
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/register_alu_execute_unit.sv =====
// Register ALU execute unit: runs one register instruction per transaction on an
// 8 x 16-bit register file and a 5-bit status word (C, V, N, Z, sleep) and returns
// the destination value and the flags. Each instruction passes an input register
// (register file read) and a result register; a new input is taken every cycle unless
// the result side stalls or a swap holds the input register. A swap writes the source
// register first, then the destination on retiring: two writes through the single write port.
// The register file reads as zero after reset until an entry is written.
`default_nettype none

`include "register_alu_execute_unit_defines.svh"

module register_alu_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[4:0], dest_reg[7:5], src_reg[10:8], operand_value[26:11], flag_mask[31:27]
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_value[15:0], status_out[20:16], zero[23:21]
  output logic      [23:0] out_tdata
);

  localparam int AW = raeu_pkg::REG_AW;
  localparam int DW = raeu_pkg::DATA_W;
  localparam int FW = raeu_pkg::FLAG_W;
  localparam int NR = raeu_pkg::NUM_REGS;
  localparam int IW = raeu_pkg::IDX_W;

  // input fields
  logic [raeu_pkg::CMD_W-1:0] in_cmd;
  logic [IW-1:0]              in_dest;
  logic [IW-1:0]              in_src;
  logic [DW-1:0]              in_op;
  logic [FW-1:0]              in_mask;
  logic                       in_accept;
  logic                       in_d_rng;
  logic                       in_s_rng;

  assign in_cmd    = in_tdata[4:0];
  assign in_dest   = in_tdata[7:5];
  assign in_src    = in_tdata[10:8];
  assign in_op     = in_tdata[26:11];
  assign in_mask   = in_tdata[31:27];
  assign in_accept = in_tvalid && in_tready;
  assign in_d_rng  = int'(in_dest) < NR;
  assign in_s_rng  = int'(in_src) < NR;

  // execute stage registers
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       swap_half_r, swap_half_nxt;
  logic [raeu_pkg::CMD_W-1:0] s1_cmd_r, s1_cmd_nxt;
  logic [IW-1:0]              s1_dest_r, s1_dest_nxt;
  logic [IW-1:0]              s1_src_r, s1_src_nxt;
  logic [DW-1:0]              s1_op_r, s1_op_nxt;
  logic [FW-1:0]              s1_mask_r, s1_mask_nxt;
  logic                       a_fwd_r, a_fwd_nxt;
  logic                       a_vld_r, a_vld_nxt;
  logic [DW-1:0]              a_fwd_data_r, a_fwd_data_nxt;
  logic                       b_fwd_r, b_fwd_nxt;
  logic                       b_vld_r, b_vld_nxt;
  logic [DW-1:0]              b_fwd_data_r, b_fwd_data_nxt;

  // architectural state
  logic [NR-1:0]              vld_r, vld_nxt;
  logic [FW-1:0]              flags_r, flags_nxt;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic [DW-1:0]              res_r, res_nxt;
  logic [FW-1:0]              stat_r, stat_nxt;

  // register file ports
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [DW-1:0]              wr_data;
  logic [AW-1:0]              rd_addr_d;
  logic [AW-1:0]              rd_addr_s;
  logic [DW-1:0]              ram_q_d;
  logic [DW-1:0]              ram_q_s;

  // execute signals
  logic                       d_rng;
  logic                       s_rng;
  logic                       is_swap;
  logic                       swap_first;
  logic                       adv;
  logic [DW-1:0]              a_val;
  logic [DW-1:0]              s_val;
  logic                       is_sub;
  logic                       cin;
  logic [DW:0]                sum;
  logic [DW-1:0]              r;
  logic                       wr;
  logic                       upd_nz;

  assign rd_addr_d = AW'(in_dest);
  assign rd_addr_s = AW'(in_src);

  raeu_ram #(
    .WIDTH (DW),
    .DEPTH (NR)
  ) u_rf_d (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr_d),
    .rd_data (ram_q_d)
  );

  raeu_ram #(
    .WIDTH (DW),
    .DEPTH (NR)
  ) u_rf_s (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr_s),
    .rd_data (ram_q_s)
  );

  assign d_rng      = int'(s1_dest_r) < NR;
  assign s_rng      = int'(s1_src_r) < NR;
  assign is_swap    = s1_cmd_r == raeu_pkg::CMD_SWAP;
  assign swap_first = s1_valid_r && is_swap && !swap_half_r;
  assign adv        = s1_valid_r && !swap_first && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;

  // operands with bypass of the write landing at the read edge
  assign a_val = a_fwd_r ? a_fwd_data_r : (a_vld_r ? ram_q_d : '0);
  assign s_val = b_fwd_r ? b_fwd_data_r : (b_vld_r ? ram_q_s : '0);

  // shared adder, subtract as a + ~b + ~borrow
  always_comb begin
    is_sub = (s1_cmd_r == raeu_pkg::CMD_SUB) || (s1_cmd_r == raeu_pkg::CMD_SUBC) ||
             (s1_cmd_r == raeu_pkg::CMD_CMP);
    unique case (s1_cmd_r)
      raeu_pkg::CMD_ADDC: cin = flags_r[raeu_pkg::FLAG_C];
      raeu_pkg::CMD_SUBC: cin = !flags_r[raeu_pkg::FLAG_C];
      default:            cin = is_sub;
    endcase
    sum = {1'b0, a_val} + {1'b0, (is_sub ? ~s1_op_r : s1_op_r)} + {{DW{1'b0}}, cin};
  end

  always_comb begin
    r         = a_val;
    wr        = 1'b1;
    upd_nz    = 1'b1;
    flags_nxt = flags_r;
    unique case (s1_cmd_r)
      raeu_pkg::CMD_ADD, raeu_pkg::CMD_ADDC: begin
        r                          = sum[DW-1:0];
        flags_nxt[raeu_pkg::FLAG_C] = sum[DW];
        flags_nxt[raeu_pkg::FLAG_V] = !(a_val[DW-1] ^ s1_op_r[DW-1]) &&
                                      (a_val[DW-1] ^ sum[DW-1]);
      end
      raeu_pkg::CMD_SUB, raeu_pkg::CMD_SUBC, raeu_pkg::CMD_CMP: begin
        r                          = sum[DW-1:0];
        wr                         = s1_cmd_r != raeu_pkg::CMD_CMP;
        flags_nxt[raeu_pkg::FLAG_C] = !sum[DW];
        flags_nxt[raeu_pkg::FLAG_V] = (a_val[DW-1] ^ s1_op_r[DW-1]) &&
                                      (a_val[DW-1] ^ sum[DW-1]);
      end
      raeu_pkg::CMD_XOR:  r = a_val ^ s1_op_r;
      raeu_pkg::CMD_AND:  r = a_val & s1_op_r;
      raeu_pkg::CMD_OR:   r = a_val | s1_op_r;
      raeu_pkg::CMD_BIT: begin
        r  = a_val & s1_op_r;
        wr = 1'b0;
      end
      raeu_pkg::CMD_BIC:  r = a_val & ~s1_op_r;
      raeu_pkg::CMD_BIS:  r = a_val | s1_op_r;
      raeu_pkg::CMD_MOV:  r = s1_op_r;
      raeu_pkg::CMD_SWAP: begin
        r      = s_val;
        upd_nz = 1'b0;
      end
      raeu_pkg::CMD_SRA:  r = {a_val[DW-1], a_val[DW-1:1]};
      raeu_pkg::CMD_RRC: begin
        r                          = {flags_r[raeu_pkg::FLAG_C], a_val[DW-1:1]};
        flags_nxt[raeu_pkg::FLAG_C] = a_val[0];
      end
      raeu_pkg::CMD_SWPB: r = {a_val[7:0], a_val[15:8]};
      raeu_pkg::CMD_SXT:  r = {{8{a_val[7]}}, a_val[7:0]};
      raeu_pkg::CMD_MOVL: begin
        r      = {a_val[15:8], s1_op_r[7:0]};
        upd_nz = 1'b0;
      end
      raeu_pkg::CMD_MOVLZ: begin
        r      = {8'h00, s1_op_r[7:0]};
        upd_nz = 1'b0;
      end
      raeu_pkg::CMD_MOVLS: begin
        r      = {8'hFF, s1_op_r[7:0]};
        upd_nz = 1'b0;
      end
      raeu_pkg::CMD_MOVH: begin
        r      = {s1_op_r[7:0], a_val[7:0]};
        upd_nz = 1'b0;
      end
      raeu_pkg::CMD_SETCC: begin
        wr        = 1'b0;
        upd_nz    = 1'b0;
        flags_nxt = flags_r | s1_mask_r;
      end
      raeu_pkg::CMD_CLRCC: begin
        wr        = 1'b0;
        upd_nz    = 1'b0;
        flags_nxt = flags_r & ~s1_mask_r;
      end
      default: begin
        wr     = 1'b0;
        upd_nz = 1'b0;
      end
    endcase
    if (upd_nz) begin
      flags_nxt[raeu_pkg::FLAG_N] = r[DW-1];
      flags_nxt[raeu_pkg::FLAG_Z] = r == '0;
    end
    if (!adv) begin
      flags_nxt = flags_r;
    end
  end

  // first swap cycle writes the source register, the retiring cycle the destination
  always_comb begin
    if (swap_first) begin
      wr_en   = s_rng;
      wr_addr = AW'(s1_src_r);
      wr_data = a_val;
    end else begin
      wr_en   = adv && wr && d_rng;
      wr_addr = AW'(s1_dest_r);
      wr_data = r;
    end
    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt   = in_accept || (s1_valid_r && !adv);
    swap_half_nxt  = adv ? 1'b0 : (swap_first ? 1'b1 : swap_half_r);
    s1_cmd_nxt     = in_accept ? in_cmd  : s1_cmd_r;
    s1_dest_nxt    = in_accept ? in_dest : s1_dest_r;
    s1_src_nxt     = in_accept ? in_src  : s1_src_r;
    s1_op_nxt      = in_accept ? in_op   : s1_op_r;
    s1_mask_nxt    = in_accept ? in_mask : s1_mask_r;
    a_fwd_nxt      = in_accept ? (in_d_rng && wr_en && wr_addr == rd_addr_d) : a_fwd_r;
    a_vld_nxt      = in_accept ? (in_d_rng && vld_r[rd_addr_d]) : a_vld_r;
    a_fwd_data_nxt = in_accept ? wr_data : a_fwd_data_r;
    b_fwd_nxt      = in_accept ? (in_s_rng && wr_en && wr_addr == rd_addr_s) : b_fwd_r;
    b_vld_nxt      = in_accept ? (in_s_rng && vld_r[rd_addr_s]) : b_vld_r;
    b_fwd_data_nxt = in_accept ? wr_data : b_fwd_data_r;
    out_valid_nxt  = adv || (out_valid_r && !out_tready);
    res_nxt        = adv ? r : res_r;
    stat_nxt       = adv ? flags_nxt : stat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      swap_half_r <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      swap_half_r <= swap_half_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r     <= s1_cmd_nxt;
    s1_dest_r    <= s1_dest_nxt;
    s1_src_r     <= s1_src_nxt;
    s1_op_r      <= s1_op_nxt;
    s1_mask_r    <= s1_mask_nxt;
    a_fwd_r      <= a_fwd_nxt;
    a_vld_r      <= a_vld_nxt;
    a_fwd_data_r <= a_fwd_data_nxt;
    b_fwd_r      <= b_fwd_nxt;
    b_vld_r      <= b_vld_nxt;
    b_fwd_data_r <= b_fwd_data_nxt;
    res_r        <= res_nxt;
    stat_r       <= stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, stat_r, res_r};

  `RAEU_ASSERT_NEXT(a_swap_second_half, swap_first, swap_half_r && s1_valid_r,
    "swap did not move to its second cycle")
  `RAEU_ASSERT_NOW(a_swap_blocks_input, swap_first, !in_tready,
    "input taken during first swap cycle")
  `RAEU_ASSERT_NEXT(a_flags_hold, !adv, $stable(flags_r),
    "flags changed without a retiring instruction")
  `RAEU_ASSERT_NEXT(a_sleep_only_cc,
    adv && s1_cmd_r != raeu_pkg::CMD_SETCC && s1_cmd_r != raeu_pkg::CMD_CLRCC,
    flags_r[raeu_pkg::FLAG_SLP] == $past(flags_r[raeu_pkg::FLAG_SLP]),
    "sleep flag changed outside setcc or clrcc")
  `RAEU_ASSERT_NEXT(a_retire_loads_out, adv, out_valid_r,
    "retiring instruction left no result")

endmodule

`default_nettype wire

// ===== rtl/core/raeu_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module raeu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                   wr_data,
  input  wire logic                               rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                   rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking stream testbench for the register alu execute unit
`default_nettype none

module testbench;
  import raeu_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          RANDOM_ITEMS  = 1750;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [4:0]  CMD_NOP_FIRST = 5'd23;
  localparam logic [4:0]  CMD_NOP_LAST  = 5'd31;

  typedef struct {
    logic [4:0]  cmd;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [15:0] opv;
    logic [4:0]  mask;
    bit          typed;
    logic [15:0] want_res;
    logic [4:0]  want_flags;
  } instr_row_t;

  typedef struct {
    logic [15:0] res;
    logic [4:0]  flags;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // typed expectation riding along with the offered transaction
  bit          row_typed = 1'b0;
  logic [15:0] row_res = '0;
  logic [4:0]  row_flags = '0;

  logic [15:0] reg_model [8];
  logic [4:0]  flag_model;
  retire_t     retire_q [$];
  instr_row_t  stim_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int unsigned cycle_cnt = 0;

  register_alu_execute_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic instr_row_t row(logic [4:0] cmd, logic [2:0] dst, logic [2:0] src,
                                     logic [15:0] opv, logic [4:0] mask, bit typed = 1'b0,
                                     logic [15:0] want_res = '0, logic [4:0] want_flags = '0);
    instr_row_t r;
    r.cmd = cmd;
    r.dst = dst;
    r.src = src;
    r.opv = opv;
    r.mask = mask;
    r.typed = typed;
    r.want_res = want_res;
    r.want_flags = want_flags;
    return r;
  endfunction

  function automatic instr_row_t random_row();
    logic [4:0]  cmd;
    logic [15:0] opv;
    if ($urandom_range(0, 9) == 0) cmd = 5'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
    else cmd = 5'($urandom_range(CMD_ADD, CMD_CLRCC));
    case ($urandom_range(0, 5))
      0: opv = 16'h0000;
      1: opv = 16'hFFFF;
      2: opv = 16'h8000;
      3: opv = 16'h7FFF;
      default: opv = 16'($urandom);
    endcase
    return row(cmd, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), opv,
               5'($urandom_range(0, 31)));
  endfunction

  // executes one instruction on the shadow register file and flags
  function automatic retire_t execute_model(logic [31:0] word);
    logic [4:0]  cmd;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [15:0] opv;
    logic [4:0]  mask;
    logic [15:0] a;
    logic [15:0] r;
    logic [16:0] full;
    logic [16:0] subtrahend;
    logic        cin;
    bit          wr;
    bit          nz;
    retire_t     ret;
    cmd  = word[4:0];
    dst  = word[7:5];
    src  = word[10:8];
    opv  = word[26:11];
    mask = word[31:27];
    a    = reg_model[dst];
    r    = a;
    wr   = 1'b1;
    nz   = 1'b1;
    cin  = flag_model[FLAG_C];
    case (cmd)
      CMD_ADD, CMD_ADDC: begin
        full = {1'b0, a} + {1'b0, opv} + ((cmd == CMD_ADDC) ? {16'd0, cin} : 17'd0);
        r = full[15:0];
        flag_model[FLAG_C] = full[16];
        flag_model[FLAG_V] = (a[15] == opv[15]) && (r[15] != a[15]);
      end
      CMD_SUB, CMD_SUBC, CMD_CMP: begin
        subtrahend = {1'b0, opv} + ((cmd == CMD_SUBC) ? {16'd0, cin} : 17'd0);
        full = {1'b0, a} - subtrahend;
        r = full[15:0];
        flag_model[FLAG_C] = {1'b0, a} < subtrahend;
        flag_model[FLAG_V] = (a[15] != opv[15]) && (r[15] != a[15]);
        wr = (cmd != CMD_CMP);
      end
      CMD_XOR: r = a ^ opv;
      CMD_AND: r = a & opv;
      CMD_OR, CMD_BIS: r = a | opv;
      CMD_BIT: begin
        r = a & opv;
        wr = 1'b0;
      end
      CMD_BIC: r = a & ~opv;
      CMD_MOV: r = opv;
      CMD_SWAP: begin
        r = reg_model[src];
        reg_model[src] = a;
        nz = 1'b0;
      end
      CMD_SRA: r = {a[15], a[15:1]};
      CMD_RRC: begin
        r = {cin, a[15:1]};
        flag_model[FLAG_C] = a[0];
      end
      CMD_SWPB: r = {a[7:0], a[15:8]};
      CMD_SXT: r = {{8{a[7]}}, a[7:0]};
      CMD_MOVL, CMD_MOVLZ, CMD_MOVLS, CMD_MOVH: begin
        nz = 1'b0;
        case (cmd)
          CMD_MOVL:  r = {a[15:8], opv[7:0]};
          CMD_MOVLZ: r = {8'h00, opv[7:0]};
          CMD_MOVLS: r = {8'hFF, opv[7:0]};
          default:   r = {opv[7:0], a[7:0]};
        endcase
      end
      CMD_SETCC: begin
        flag_model = flag_model | mask;
        wr = 1'b0;
        nz = 1'b0;
      end
      CMD_CLRCC: begin
        flag_model = flag_model & ~mask;
        wr = 1'b0;
        nz = 1'b0;
      end
      default: begin
        wr = 1'b0;
        nz = 1'b0;
      end
    endcase
    if (nz) begin
      flag_model[FLAG_N] = r[15];
      flag_model[FLAG_Z] = (r == 16'h0000);
    end
    if (wr) reg_model[dst] = r;
    ret.res = r;
    ret.flags = flag_model;
    return ret;
  endfunction

  // transactions are judged at the falling edge, where every signal is settled
  always @(negedge clk) begin
    retire_t pred;
    retire_t want;
    if (rst_n && in_tvalid && in_tready) begin
      pred = execute_model(in_tdata);
      if (row_typed) begin
        pred.res = row_res;
        pred.flags = row_flags;
      end
      retire_q.push_back(pred);
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (retire_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual %h", $time, out_tdata);
      end else begin
        want = retire_q.pop_front();
        if (out_tdata[15:0] !== want.res) begin
          mismatches++;
          $display("%0t result_value mismatch: expected %h actual %h",
                   $time, want.res, out_tdata[15:0]);
        end
        if (out_tdata[20:16] !== want.flags) begin
          mismatches++;
          $display("%0t status_out mismatch: expected %h actual %h",
                   $time, want.flags, out_tdata[20:16]);
        end
      end
    end
  end

  // result side stall pattern, with one long hold-off to back the block up
  initial begin
    int  mode;
    int  len;
    bit  held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
      if (!held && results_seen > 600) begin
        @(posedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
    end
  end

  initial begin
    instr_row_t it;
    int         directed_cnt;
    int         burst;
    int         gap;
    int         idx;
    bit         fired;
    for (int i = 0; i < 8; i++) reg_model[i] = '0;
    flag_model = '0;

    stim_q.push_back(row(CMD_SETCC, 3'd0, 3'd0, 16'h0000, 5'h1F, 1'b1, 16'h0000, 5'h1F));
    stim_q.push_back(row(CMD_CLRCC, 3'd0, 3'd0, 16'hFFFF, 5'h1F, 1'b1, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_MOV,   3'd1, 3'd0, 16'hFFFF, 5'h00, 1'b1, 16'hFFFF, 5'h04));
    stim_q.push_back(row(CMD_ADD,   3'd1, 3'd0, 16'h0001, 5'h00, 1'b1, 16'h0000, 5'h09));
    stim_q.push_back(row(CMD_NOP_LAST, 3'd1, 3'd7, 16'hFFFF, 5'h1F, 1'b1, 16'h0000, 5'h09));
    stim_q.push_back(row(CMD_MOV,   3'd2, 3'd0, 16'h7FFF, 5'h00));
    stim_q.push_back(row(CMD_ADD,   3'd2, 3'd0, 16'h0001, 5'h00));
    stim_q.push_back(row(CMD_SUB,   3'd3, 3'd0, 16'h0001, 5'h00));
    stim_q.push_back(row(CMD_ADDC,  3'd3, 3'd0, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_SUBC,  3'd4, 3'd0, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_CMP,   3'd2, 3'd0, 16'h8000, 5'h00));
    stim_q.push_back(row(CMD_XOR,   3'd5, 3'd0, 16'hFFFF, 5'h00));
    stim_q.push_back(row(CMD_AND,   3'd5, 3'd0, 16'h00FF, 5'h00));
    stim_q.push_back(row(CMD_OR,    3'd5, 3'd0, 16'hF0F0, 5'h00));
    stim_q.push_back(row(CMD_BIT,   3'd5, 3'd0, 16'h8000, 5'h00));
    stim_q.push_back(row(CMD_BIC,   3'd5, 3'd0, 16'h0F0F, 5'h00));
    stim_q.push_back(row(CMD_BIS,   3'd6, 3'd0, 16'h8001, 5'h00));
    stim_q.push_back(row(CMD_SWAP,  3'd5, 3'd6, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_SWAP,  3'd7, 3'd7, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_SRA,   3'd6, 3'd0, 16'hFFFF, 5'h00));
    stim_q.push_back(row(CMD_RRC,   3'd6, 3'd0, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_SWPB,  3'd6, 3'd0, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_SXT,   3'd6, 3'd0, 16'h0000, 5'h00));
    stim_q.push_back(row(CMD_MOVL,  3'd7, 3'd0, 16'hFFAA, 5'h00));
    stim_q.push_back(row(CMD_MOVLZ, 3'd0, 3'd0, 16'hFF80, 5'h00));
    stim_q.push_back(row(CMD_MOVLS, 3'd1, 3'd0, 16'h0012, 5'h00));
    stim_q.push_back(row(CMD_MOVH,  3'd2, 3'd0, 16'h00FF, 5'h00));
    directed_cnt = stim_q.size();
    for (int i = 0; i < RANDOM_ITEMS; i++) stim_q.push_back(random_row());

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && idx < stim_q.size()) begin
        it = stim_q[idx];
        in_tvalid <= 1'b1;
        in_tdata  <= {it.mask, it.opv, it.src, it.dst, it.cmd};
        row_typed <= it.typed;
        row_res   <= it.want_res;
        row_flags <= it.want_flags;
        do begin
          @(negedge clk);
          fired = in_tready;
          @(posedge clk);
        end while (!fired);
        idx++;
        burst--;
        // wait for the pipeline to empty after the directed table and once mid-run
        if (idx == directed_cnt || idx == directed_cnt + RANDOM_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          while (retire_q.size() != 0) @(posedge clk);
          burst = 0;
          gap = 0;
        end
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (retire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/raeu_pkg.sv
rtl/core/raeu_ram.sv
rtl/core/register_alu_execute_unit.sv
tb/testbench.sv
